FILE: design/holm_pkg.sv
// Package for the operator longest-match block: beat types, operator classes
// and the constant operator table. No dependencies.
`default_nettype none

package holm_pkg;

  // Window geometry
  localparam int unsigned WIN_BYTES = 4;
  localparam int unsigned LEN_W     = 3;
  localparam int unsigned CODE_W    = 5;
  localparam int unsigned NUM_OPS   = 57;
  localparam logic [LEN_W-1:0] WIN_LEN = LEN_W'(WIN_BYTES);

  // Operator classes selected by the command field
  typedef enum logic [1:0] {
    CLS_BINARY = 2'd0,
    CLS_ASSIGN = 2'd1,
    CLS_UNARY  = 2'd2,
    CLS_INCDEC = 2'd3
  } op_class_t;

  // Request beat
  typedef struct packed {
    logic [1:0]       command;
    logic [7:0]       char_0;
    logic [7:0]       char_1;
    logic [7:0]       char_2;
    logic [7:0]       char_3;
    logic [LEN_W-1:0] bytes_available;
  } req_t;

  // Response beat
  typedef struct packed {
    logic              matched;
    logic [CODE_W-1:0] operator_code;
    logic [LEN_W-1:0]  consumed_length;
  } rsp_t;

  // One table entry; spelling is left aligned, first byte in the top byte
  typedef struct packed {
    op_class_t         cls;
    logic [LEN_W-1:0]  len;
    logic [31:0]       text;
    logic [CODE_W-1:0] code;
  } op_entry_t;

  function automatic op_entry_t op1(op_class_t c, logic [7:0] s, logic [CODE_W-1:0] k);
    op_entry_t e;
    e.cls  = c;
    e.len  = 3'd1;
    e.text = {s, 24'h0};
    e.code = k;
    return e;
  endfunction

  function automatic op_entry_t op2(op_class_t c, logic [15:0] s, logic [CODE_W-1:0] k);
    op_entry_t e;
    e.cls  = c;
    e.len  = 3'd2;
    e.text = {s, 16'h0};
    e.code = k;
    return e;
  endfunction

  function automatic op_entry_t op3(op_class_t c, logic [23:0] s, logic [CODE_W-1:0] k);
    op_entry_t e;
    e.cls  = c;
    e.len  = 3'd3;
    e.text = {s, 8'h0};
    e.code = k;
    return e;
  endfunction

  function automatic op_entry_t op4(op_class_t c, logic [31:0] s, logic [CODE_W-1:0] k);
    op_entry_t e;
    e.cls  = c;
    e.len  = 3'd4;
    e.text = s;
    e.code = k;
    return e;
  endfunction

  // Operator table, each class in its own order
  localparam op_entry_t OP_TABLE [NUM_OPS] = '{
    // binary
    op1(CLS_BINARY, "+", 5'd0),    op1(CLS_BINARY, "-", 5'd1),
    op1(CLS_BINARY, "*", 5'd2),    op1(CLS_BINARY, "/", 5'd3),
    op1(CLS_BINARY, "%", 5'd4),    op2(CLS_BINARY, "**", 5'd5),
    op1(CLS_BINARY, "<", 5'd6),    op1(CLS_BINARY, ">", 5'd7),
    op2(CLS_BINARY, "<=", 5'd8),   op2(CLS_BINARY, ">=", 5'd9),
    op3(CLS_BINARY, "===", 5'd10), op3(CLS_BINARY, "!==", 5'd11),
    op2(CLS_BINARY, "==", 5'd12),  op2(CLS_BINARY, "!=", 5'd13),
    op3(CLS_BINARY, "==?", 5'd14), op3(CLS_BINARY, "!=?", 5'd15),
    op2(CLS_BINARY, "&&", 5'd16),  op2(CLS_BINARY, "||", 5'd17),
    op2(CLS_BINARY, "->", 5'd18),  op3(CLS_BINARY, "<->", 5'd19),
    op1(CLS_BINARY, "!", 5'd20),   op1(CLS_BINARY, "&", 5'd21),
    op1(CLS_BINARY, "|", 5'd22),   op1(CLS_BINARY, "^", 5'd23),
    op2(CLS_BINARY, "^~", 5'd24),  op2(CLS_BINARY, "~^", 5'd24),
    op1(CLS_BINARY, "~", 5'd25),   op2(CLS_BINARY, "<<", 5'd26),
    op2(CLS_BINARY, ">>", 5'd27),  op3(CLS_BINARY, "<<<", 5'd28),
    op3(CLS_BINARY, ">>>", 5'd29),
    // assignment
    op1(CLS_ASSIGN, "=", 5'd0),    op2(CLS_ASSIGN, "+=", 5'd1),
    op2(CLS_ASSIGN, "-=", 5'd2),   op2(CLS_ASSIGN, "*=", 5'd3),
    op2(CLS_ASSIGN, "/=", 5'd4),   op2(CLS_ASSIGN, "%=", 5'd5),
    op2(CLS_ASSIGN, "&=", 5'd6),   op2(CLS_ASSIGN, "|=", 5'd7),
    op2(CLS_ASSIGN, "^=", 5'd8),   op3(CLS_ASSIGN, "<<=", 5'd9),
    op3(CLS_ASSIGN, ">>=", 5'd10), op4(CLS_ASSIGN, "<<<=", 5'd11),
    op4(CLS_ASSIGN, ">>>=", 5'd12),
    // unary
    op1(CLS_UNARY, "+", 5'd0),     op1(CLS_UNARY, "-", 5'd1),
    op1(CLS_UNARY, "!", 5'd2),     op1(CLS_UNARY, "~", 5'd3),
    op1(CLS_UNARY, "&", 5'd4),     op2(CLS_UNARY, "~&", 5'd5),
    op1(CLS_UNARY, "|", 5'd6),     op2(CLS_UNARY, "~|", 5'd7),
    op1(CLS_UNARY, "^", 5'd8),     op2(CLS_UNARY, "~^", 5'd9),
    op2(CLS_UNARY, "^~", 5'd9),
    // increment / decrement
    op2(CLS_INCDEC, "++", 5'd0),   op2(CLS_INCDEC, "--", 5'd1)
  };

endpackage

`default_nettype wire

FILE: design/holm_match.sv
// Combinational longest-match search over the operator table.
// Depends on holm_pkg.
`default_nettype none

module holm_match (
  input  holm_pkg::req_t req,
  output holm_pkg::rsp_t rsp
);
  import holm_pkg::*;

  logic [LEN_W-1:0]  avail;
  logic [31:0]       window;
  logic [WIN_BYTES-1:0] hit_len;
  logic [CODE_W-1:0] code_len [WIN_BYTES];

  // Clamp the byte count to the window size
  assign avail  = (req.bytes_available > WIN_LEN) ? WIN_LEN : req.bytes_available;
  assign window = {req.char_0, req.char_1, req.char_2, req.char_3};

  // Per-length hit and code; within a class, at most one spelling of a
  // given length can match, so OR-ing the codes is enough
  always_comb begin
    logic hit;
    logic [1:0] slot;
    hit_len = '0;
    for (int l = 0; l < WIN_BYTES; l++) begin
      code_len[l] = '0;
    end
    for (int k = 0; k < NUM_OPS; k++) begin
      hit = (OP_TABLE[k].cls == op_class_t'(req.command)) && (OP_TABLE[k].len <= avail);
      for (int i = 0; i < WIN_BYTES; i++) begin
        if (i < int'(OP_TABLE[k].len) &&
            window[31-8*i -: 8] != OP_TABLE[k].text[31-8*i -: 8]) begin
          hit = 1'b0;
        end
      end
      slot = 2'(OP_TABLE[k].len - 3'd1);
      hit_len[slot] = hit_len[slot] | hit;
      code_len[slot] = code_len[slot] | (hit ? OP_TABLE[k].code : '0);
    end
  end

  // Longest length wins
  always_comb begin
    rsp = '0;
    for (int l = 0; l < WIN_BYTES; l++) begin
      if (hit_len[l]) begin
        rsp.matched         = 1'b1;
        rsp.operator_code   = code_len[l];
        rsp.consumed_length = LEN_W'(l + 1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/hdl_operator_longest_match_core.sv
// Top level of the operator longest-match block: input register, match
// logic and response register. Depends on holm_pkg and holm_match.
`default_nettype none

// Usage
//   req channel: one beat carries the operator class (command), a four-byte
//   lookahead window and the count of window bytes before end of input.
//   rsp channel: one beat per request with matched, operator_code and
//   consumed_length (0/0/0 when nothing of the class matches).
//   Both channels are valid/ready; a beat moves when both are high.
// Path: an accepted request goes into the input register, then the table
//   compare result goes into the response register.
// Throughput: one beat per cycle while rsp_ready is high; the table compare
//   is a single pass of parallel byte compares between the two registers.
// Stall: when rsp_ready is low the response register holds; the input
//   register still takes one more request, after which req_ready drops
//   until the response is taken. No beat is dropped or repeated.
// Reset: rst (synchronous, active high) empties both registers; req_ready
//   is high in the first cycle after reset.
module hdl_operator_longest_match_core (
  input  wire             clk,
  input  wire             rst,
  input  wire             req_valid,
  output logic            req_ready,
  input  holm_pkg::req_t  req,
  output logic            rsp_valid,
  input  wire             rsp_ready,
  output holm_pkg::rsp_t  rsp
);
  import holm_pkg::*;

  logic s1_valid;
  req_t s1_req;
  rsp_t match_rsp;
  logic s1_adv;

  // Stage 1 moves on when the response register is empty or draining
  assign s1_adv    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_adv;

  holm_match u_match (
    .req (s1_req),
    .rsp (match_rsp)
  );

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_ready) begin
        s1_valid <= req_valid;
      end
      if (!rsp_valid || rsp_ready) begin
        rsp_valid <= s1_valid;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_req <= req;
    end
    if (s1_adv) begin
      rsp <= match_rsp;
    end
  end

  // Checks
  a_match_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.matched == (rsp.consumed_length != '0)))
    else $error("matched flag disagrees with consumed length");

  a_nomatch_code: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.matched) |-> (rsp.operator_code == '0))
    else $error("nonzero code without a match");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.consumed_length <= WIN_LEN))
    else $error("consumed length beyond window");

  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> s1_valid)
    else $error("accepted request lost before stage 1");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready && s1_valid) |=> (s1_valid && $stable(s1_req)))
    else $error("stage 1 changed while the response stalled");

endmodule

`default_nettype wire

FILE: sim/holm_match_checker.sv
// Checker for the operator longest-match block: watches the request and
// response channels, predicts each response and compares it field by field.
// Depends on holm_pkg.

module holm_match_checker (
  input  wire            clk,
  input  wire            rst,
  input  wire            req_valid,
  input  wire            req_ready,
  input  holm_pkg::req_t req,
  input  wire            rsp_valid,
  input  wire            rsp_ready,
  input  holm_pkg::rsp_t rsp,
  output int             mismatch_count,
  output int             pending_count
);
  import holm_pkg::*;

  // Operator spellings per class, in table order, with their dense codes
  string binary_spellings [31] = '{
    "+", "-", "*", "/", "%", "**", "<", ">", "<=", ">=", "===", "!==", "==", "!=",
    "==?", "!=?", "&&", "||", "->", "<->", "!", "&", "|", "^", "^~", "~^", "~",
    "<<", ">>", "<<<", ">>>"
  };
  int binary_codes [31] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20,
    21, 22, 23, 24, 24, 25, 26, 27, 28, 29
  };
  string assign_spellings [13] = '{
    "=", "+=", "-=", "*=", "/=", "%=", "&=", "|=", "^=", "<<=", ">>=", "<<<=", ">>>="
  };
  string unary_spellings [11] = '{
    "+", "-", "!", "~", "&", "~&", "|", "~|", "^", "~^", "^~"
  };
  int unary_codes [11] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 9};
  string incdec_spellings [2] = '{"++", "--"};

  rsp_t expected_rsps [$];
  int   fails   = 0;
  int   waiting = 0;

  assign mismatch_count = fails;
  assign pending_count  = waiting;

  // Keep the spelling if it fits in the live bytes and beats the best so far;
  // strictly longer only, so the earlier entry wins a tie
  function automatic void try_spelling(input string s, input int code,
                                       input logic [31:0] win, input int avail,
                                       inout int best_len, inout int best_code);
    int  n;
    bit  hit;
    n   = s.len();
    hit = (n <= avail);
    for (int i = 0; i < n; i++) begin
      if (s[i] != win[31-8*i -: 8]) hit = 1'b0;
    end
    if (hit && n > best_len) begin
      best_len  = n;
      best_code = code;
    end
  endfunction

  // Longest operator of the selected class that prefixes the live window
  function automatic rsp_t munch_operator(input req_t r);
    logic [31:0] win;
    int          avail;
    int          best_len;
    int          best_code;
    rsp_t        p;
    win       = {r.char_0, r.char_1, r.char_2, r.char_3};
    avail     = (r.bytes_available > WIN_BYTES) ? WIN_BYTES : int'(r.bytes_available);
    best_len  = 0;
    best_code = 0;
    case (op_class_t'(r.command))
      CLS_BINARY: begin
        foreach (binary_spellings[i])
          try_spelling(binary_spellings[i], binary_codes[i], win, avail, best_len, best_code);
      end
      CLS_ASSIGN: begin
        foreach (assign_spellings[i])
          try_spelling(assign_spellings[i], i, win, avail, best_len, best_code);
      end
      CLS_UNARY: begin
        foreach (unary_spellings[i])
          try_spelling(unary_spellings[i], unary_codes[i], win, avail, best_len, best_code);
      end
      default: begin
        foreach (incdec_spellings[i])
          try_spelling(incdec_spellings[i], i, win, avail, best_len, best_code);
      end
    endcase
    p.matched         = (best_len != 0);
    p.operator_code   = CODE_W'(best_code);
    p.consumed_length = LEN_W'(best_len);
    return p;
  endfunction

  // Predict on each request beat, compare on each response beat
  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) expected_rsps.push_back(munch_operator(req));
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          fails++;
          $display("%0t: response beat with none expected (got %0d/%0d/%0d)", $time,
                   rsp.matched, rsp.operator_code, rsp.consumed_length);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.matched !== want.matched) begin
            fails++;
            $display("%0t: matched expected %0d got %0d", $time, want.matched, rsp.matched);
          end
          if (rsp.operator_code !== want.operator_code) begin
            fails++;
            $display("%0t: operator_code expected %0d got %0d", $time,
                     want.operator_code, rsp.operator_code);
          end
          if (rsp.consumed_length !== want.consumed_length) begin
            fails++;
            $display("%0t: consumed_length expected %0d got %0d", $time,
                     want.consumed_length, rsp.consumed_length);
          end
        end
      end
      waiting = expected_rsps.size();
    end
  end

endmodule

FILE: sim/hdl_operator_longest_match_core_test.sv
// Testbench top for hdl_operator_longest_match_core: drives request beats,
// random response back-pressure, and reports the verdict.
// Depends on holm_pkg, the block itself and holm_match_checker.

module hdl_operator_longest_match_core_test;
  import holm_pkg::*;

  localparam int RANDOM_ITEMS = 1926;

  // Every distinct operator spelling, for building well-formed windows
  string op_spellings [48] = '{
    "+", "-", "*", "/", "%", "**", "<", ">", "<=", ">=", "===", "!==", "==", "!=",
    "==?", "!=?", "&&", "||", "->", "<->", "!", "&", "|", "^", "^~", "~^", "~",
    "<<", ">>", "<<<", ">>>", "=", "+=", "-=", "*=", "/=", "%=", "&=", "|=", "^=",
    "<<=", ">>=", "<<<=", ">>>=", "~&", "~|", "++", "--"
  };
  string op_chars = "+-*/%<>=!?&|^~";

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  int   mismatch_count;
  int   pending_count;
  int   send_idle = 16;
  int   recv_idle = 50;

  hdl_operator_longest_match_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  holm_match_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Window holding a spelling, zero padded
  function automatic req_t make_window(input op_class_t cls, input string s, input int avail);
    req_t        b;
    logic [31:0] win;
    win = '0;
    for (int i = 0; i < s.len() && i < 4; i++) win[31-8*i -: 8] = s[i];
    b.command         = cls;
    {b.char_0, b.char_1, b.char_2, b.char_3} = win;
    b.bytes_available = LEN_W'(avail);
    return b;
  endfunction

  // Mostly an operator spelling followed by operator characters; some noise
  function automatic req_t random_request();
    req_t        b;
    logic [31:0] win;
    string       s;
    int          avail;
    b.command = 2'($urandom_range(3));
    if ($urandom_range(99) < 70) begin
      s = op_spellings[$urandom_range(47)];
      for (int i = 0; i < 4; i++) begin
        if (i < s.len()) win[31-8*i -: 8] = s[i];
        else if ($urandom_range(4) == 0) win[31-8*i -: 8] = 8'($urandom_range(255));
        else win[31-8*i -: 8] = op_chars[$urandom_range(op_chars.len() - 1)];
      end
      if ($urandom_range(3) == 0) avail = $urandom_range(7);
      else avail = $urandom_range(4, s.len());
    end else begin
      win   = $urandom;
      avail = $urandom_range(7);
    end
    {b.char_0, b.char_1, b.char_2, b.char_3} = win;
    b.bytes_available = LEN_W'(avail);
    return b;
  endfunction

  // One request beat, after a random idle stretch
  task automatic drive_request(input req_t beat);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= beat;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  initial begin
    req_t noise;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: table extremes, shared codes, lookahead cut by end of input
    drive_request(make_window(CLS_BINARY, "", 0));
    noise = '1;
    noise.bytes_available = 3'd7;
    drive_request(noise);
    drive_request(make_window(CLS_ASSIGN, "<<<=", 4));
    drive_request(make_window(CLS_ASSIGN, ">>>=", 7));
    drive_request(make_window(CLS_ASSIGN, "<<<=", 3));
    drive_request(make_window(CLS_BINARY, "<<<=", 4));
    drive_request(make_window(CLS_BINARY, "<->", 3));
    drive_request(make_window(CLS_BINARY, "===", 2));
    drive_request(make_window(CLS_BINARY, "!=?", 4));
    drive_request(make_window(CLS_BINARY, "^~", 2));
    drive_request(make_window(CLS_BINARY, "~^", 2));
    drive_request(make_window(CLS_BINARY, "**", 2));
    drive_request(make_window(CLS_UNARY, "~^", 2));
    drive_request(make_window(CLS_UNARY, "^~", 2));
    drive_request(make_window(CLS_UNARY, "~&", 2));
    drive_request(make_window(CLS_UNARY, "~|", 1));
    drive_request(make_window(CLS_INCDEC, "++", 2));
    drive_request(make_window(CLS_INCDEC, "--", 4));
    drive_request(make_window(CLS_INCDEC, "++", 1));
    drive_request(make_window(CLS_INCDEC, "+-", 2));
    drive_request(make_window(CLS_BINARY, ">>>", 5));
    drive_request(make_window(CLS_ASSIGN, "=", 1));
    drive_request(make_window(CLS_BINARY, "!==", 3));
    drive_request(make_window(CLS_UNARY, "+", 0));

    // Random, in three idling phases
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle = 50;
        recv_idle = 16;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      drive_request(random_request());
    end
    req_valid <= 1'b0;

    // Drain
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
design/holm_pkg.sv
design/holm_match.sv
design/hdl_operator_longest_match_core.sv
sim/holm_match_checker.sv
sim/hdl_operator_longest_match_core_test.sv
